/* src/dlm_pkg.sv */
// shared types and constants for the directional local-minimum edge map
package dlm_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int LAG_W      = DIM_W + 2;
  localparam int WIN_REACH  = 2;
  localparam int WIN_SIDE   = 2 * WIN_REACH + 1;
  localparam int LINE_COUNT = 2 * WIN_REACH;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] HEIGHT_CAP = 11'd2045;
  localparam logic [PIX_W-1:0] WHITE      = 8'd255;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } dlm_meta_t;

  localparam int META_W = $bits(dlm_meta_t);

endpackage

/* src/dlm_ram.sv */
// generic single-write, single-read ram with registered read data
module dlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dlm_fifo.sv */
// small register queue between the front and back parts
module dlm_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] dout_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

/* src/dlm_front.sv */
// front part: frame position counters, drain filtering and border classification
module dlm_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dlm_pkg::DIM_W-1:0]  image_width_i,
  input  logic [dlm_pkg::DIM_W-1:0]  image_height_i,
  input  logic                       restart_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dlm_pkg::PIX_W-1:0]  pixel_in_i,
  input  logic                       drain_i,
  input  logic                       full_i,
  output logic                       push_o,
  output logic [AW-1:0]              col_o,
  output logic [dlm_pkg::PIX_W-1:0]  pix_o,
  output dlm_pkg::dlm_meta_t         meta_o
);

  import dlm_pkg::*;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [LAG_W-1:0] lag;
  logic [DIM_W-1:0] in_col_q, in_col_d;
  // one spare bit: one-pixel rows run four tail rows past the tallest frame
  logic [DIM_W:0]   in_row_q, in_row_d;
  logic [DIM_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [LAG_W-1:0] lead_q, lead_d;
  logic             in_body, take, keep;
  dlm_meta_t        meta;

  always_comb begin
    w_eff = image_width_i;
    if (image_width_i == '0) begin
      w_eff = DIM_W'(1);
    end else if ({2'b00, image_width_i} > 13'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = image_height_i;
    if (image_height_i == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height_i > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end
  end

  // output lags the input by two rows and two columns
  assign lag = {1'b0, w_eff, 1'b0} + LAG_W'(2);

  assign in_body    = (in_row_q < {1'b0, h_eff});
  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  // a drain beat inside the frame body is dropped
  assign keep       = take && !(in_body && drain_i);

  always_comb begin
    meta.emit   = (lead_q == lag);
    meta.border = (out_row_q < DIM_W'(WIN_REACH))
               || ({1'b0, out_row_q} + 12'(WIN_REACH) >= {1'b0, h_eff})
               || (out_col_q < DIM_W'(WIN_REACH))
               || ({1'b0, out_col_q} + 12'(WIN_REACH) >= {1'b0, w_eff});
    meta.last   = (out_row_q == h_eff - 1'b1) && (out_col_q == w_eff - 1'b1);
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end else if (keep) begin
      if (in_col_q == w_eff - 1'b1) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (!meta.emit) begin
        lead_d = lead_q + 1'b1;
      end else if (meta.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        lead_d    = '0;
      end else if (out_col_q == w_eff - 1'b1) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  assign push_o = keep;
  assign col_o  = AW'(in_col_q);
  assign pix_o  = in_body ? pixel_in_i : '0;
  assign meta_o = meta;

endmodule

/* src/dlm_back.sv */
// back part: line store, 5x5 window, directional minimum test and output register
module dlm_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dlm_pkg::PIX_W-1:0]  contrast_i,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  logic [AW-1:0]              q_col_i,
  input  logic [dlm_pkg::PIX_W-1:0]  q_pix_i,
  input  dlm_pkg::dlm_meta_t         q_meta_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dlm_pkg::PIX_W-1:0]  pixel_out_o,
  output logic                       frame_last_o
);

  import dlm_pkg::*;

  localparam int LW = LINE_COUNT * PIX_W;

  function automatic logic below_pair(logic [PIX_W:0] c, pix_t a1, pix_t a2,
                                      pix_t b1, pix_t b2);
    logic [PIX_W:0] sum_a, sum_b;
    sum_a = {1'b0, a1} + {1'b0, a2};
    sum_b = {1'b0, b1} + {1'b0, b2};
    return (c < {1'b0, sum_a[PIX_W:1]}) && (c < {1'b0, sum_b[PIX_W:1]});
  endfunction

  logic            adv, pop, wr_en;
  logic [LW-1:0]   ram_rdata, line_word, wr_word;

  logic            b1_valid_q;
  logic [AW-1:0]   b1_col_q;
  pix_t            b1_pix_q;
  dlm_meta_t       b1_meta_q;
  logic            fwd_hit_q;
  logic [LW-1:0]   fwd_data_q;

  pix_t            win_q [WIN_SIDE][WIN_SIDE];
  pix_t            newcol [WIN_SIDE];

  logic            b2_valid_q;
  dlm_meta_t       b2_meta_q;
  logic [PIX_W:0]  centre;
  logic            is_min;
  pix_t            result;

  logic            out_valid_q;
  pix_t            pixel_out_q;
  logic            frame_last_q;

  // whole back pipeline moves together and holds while the output beat waits
  assign adv       = !out_valid_q || out_ready_i;
  assign pop       = adv && q_valid_i;
  assign q_ready_o = adv;
  assign wr_en     = adv && b1_valid_q;

  // same-column write and read in one cycle only happens for one-pixel rows
  assign line_word = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign wr_word   = {line_word[LW-PIX_W-1:0], b1_pix_q};

  dlm_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (b1_col_q),
    .wdata_i (wr_word),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (ram_rdata)
  );

  // oldest line on top of the new column
  always_comb begin
    for (int k = 0; k < LINE_COUNT; k++) begin
      newcol[LINE_COUNT-1-k] = line_word[k*PIX_W +: PIX_W];
    end
    newcol[LINE_COUNT] = b1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      b2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < WIN_SIDE; i++) begin
        for (int j = 0; j < WIN_SIDE; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (adv) begin
        b1_valid_q  <= pop;
        b2_valid_q  <= b1_valid_q;
        out_valid_q <= b2_valid_q && b2_meta_q.emit;
      end
      if (pop) begin
        fwd_hit_q <= wr_en && (b1_col_q == q_col_i);
      end
      if (wr_en) begin
        for (int i = 0; i < WIN_SIDE; i++) begin
          for (int j = 0; j < WIN_SIDE - 1; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
          win_q[i][WIN_SIDE-1] <= newcol[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_col_q   <= q_col_i;
      b1_pix_q   <= q_pix_i;
      b1_meta_q  <= q_meta_i;
      fwd_data_q <= wr_word;
    end
    if (adv) begin
      b2_meta_q    <= b1_meta_q;
      pixel_out_q  <= result;
      frame_last_q <= b2_meta_q.last;
    end
  end

  // diagonal, vertical, anti-diagonal, horizontal
  always_comb begin
    centre = {1'b0, win_q[2][2]} + {1'b0, contrast_i};
    is_min = below_pair(centre, win_q[1][1], win_q[0][0], win_q[3][3], win_q[4][4])
          || below_pair(centre, win_q[1][2], win_q[0][2], win_q[3][2], win_q[4][2])
          || below_pair(centre, win_q[1][3], win_q[0][4], win_q[3][1], win_q[4][0])
          || below_pair(centre, win_q[2][1], win_q[2][0], win_q[2][3], win_q[2][4]);
    if (b2_meta_q.border || (contrast_i == '0)) begin
      result = win_q[2][2];
    end else begin
      result = is_min ? '0 : WHITE;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

endmodule

/* src/directional_local_minimum_edge_map_core.sv */
// path: a window's last beat goes through the queue and the b1, b2 and output registers
// rate: one beat per cycle in and out unless stalled; line store: one ram word per column
// a frame of w*h pixels needs 2*w+2 further beats (drain or pixel) to flush its tail
// reset: counters, window and control clear, contrast 0, width 640, height 480
// reset: line store is not cleared and holds no data until the first frame writes it
module directional_local_minimum_edge_map_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dlm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dlm_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dlm_pkg::PIX_W-1:0]         pixel_in_i,
  input  logic                              drain_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dlm_pkg::PIX_W-1:0]         pixel_out_o,
  output logic                              frame_last_o
);

  import dlm_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int Q_DEPTH = 4;
  localparam int Q_W     = AW + PIX_W + META_W;

  pix_t             contrast_q;
  logic [DIM_W-1:0] image_width_q, image_height_q;
  logic             restart;

  logic             push, q_full, q_valid, q_ready;
  logic [AW-1:0]    f_col, q_col;
  pix_t             f_pix, q_pix;
  dlm_meta_t        f_meta, q_meta;
  logic [Q_W-1:0]   q_dout;

  assign restart = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) || (cfg_idx_i == CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q     <= '0;
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONTRAST: contrast_q     <= cfg_data_i[PIX_W-1:0];
        CFG_WIDTH:    image_width_q  <= cfg_data_i;
        CFG_HEIGHT:   image_height_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  dlm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .restart_i      (restart),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_in_i     (pixel_in_i),
    .drain_i        (drain_i),
    .full_i         (q_full),
    .push_o         (push),
    .col_o          (f_col),
    .pix_o          (f_pix),
    .meta_o         (f_meta)
  );

  dlm_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   ({f_col, f_pix, f_meta}),
    .full_o  (q_full),
    .pop_i   (q_ready),
    .valid_o (q_valid),
    .dout_o  (q_dout)
  );

  assign {q_col, q_pix, q_meta} = q_dout;

  dlm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .contrast_i   (contrast_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_col_i      (q_col),
    .q_pix_i      (q_pix),
    .q_meta_i     (q_meta),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  // a held output beat must freeze the back pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !q_ready)
    else $error("back part advanced while output beat was held");

  // a queued entry is not lost while the back part stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_ready |=> q_valid)
    else $error("queue entry vanished during back stall");

  // input side only closes after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready dropped without an accepted beat");

endmodule

/* verif/directional_local_minimum_edge_map_core_tb.sv */
// testbench for the directional local-minimum edge map core: directed table, random frames, then two directed frames
`timescale 1ns / 1ps

module directional_local_minimum_edge_map_core_tb;
  import dlm_pkg::*;

  localparam int          MAXW        = 1024;
  localparam int unsigned LIMIT       = 2_000_000;
  localparam int          DRAIN_PAUSE = 8;
  localparam int          RANDOM_BEATS = 450;
  localparam int          PLAN_LEN    = 26;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    pix_t pix;
    logic last;
  } edge_px_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    pix_t                 pix;
    logic                 drn;
    logic                 known;
    pix_t                 want_pix;
    logic                 want_last;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_t                 pixel_in = '0;
  logic                 drain_in = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_t                 pixel_out;
  logic                 frame_last;

  directional_local_minimum_edge_map_core #(
    .MAX_WIDTH(MAXW)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pixel_in_i  (pixel_in),
    .drain_i     (drain_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_out_o (pixel_out),
    .frame_last_o(frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  pix_t        line_mem [LINE_COUNT*MAXW];
  pix_t        win [WIN_SIDE][WIN_SIDE];
  int unsigned col_cnt, row_cnt;
  int unsigned cfg_contrast, cfg_w, cfg_h;

  edge_px_t    expected_px [$];
  plan_row_t   plan [PLAN_LEN];
  int          errors = 0;
  int          beats_done = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  function automatic int unsigned used_width();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAXW) return MAXW;
    return cfg_w;
  endfunction

  function automatic int unsigned used_height();
    if (cfg_h == 0) return 1;
    if (cfg_h > HEIGHT_CAP) return HEIGHT_CAP;
    return cfg_h;
  endfunction

  // centre plus contrast below both pair averages on any of the four lines
  function automatic bit has_dip();
    int          dr [4];
    int          dc [4];
    int unsigned ctr, near_a, far_a, near_b, far_b;
    dr = '{1, 1, 1, 0};
    dc = '{1, 0, -1, 1};
    ctr = win[WIN_REACH][WIN_REACH] + cfg_contrast;
    for (int d = 0; d < 4; d++) begin
      near_a = win[WIN_REACH - dr[d]][WIN_REACH - dc[d]];
      far_a  = win[WIN_REACH - 2*dr[d]][WIN_REACH - 2*dc[d]];
      near_b = win[WIN_REACH + dr[d]][WIN_REACH + dc[d]];
      far_b  = win[WIN_REACH + 2*dr[d]][WIN_REACH + 2*dc[d]];
      if (ctr < (near_a + far_a) / 2 && ctr < (near_b + far_b) / 2) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic edge_map_step(input pix_t pix, input logic drn,
                               output bit made, output edge_px_t res);
    int unsigned w, h, body, lag, c, n, p, rc, cc;
    pix_t        v;
    pix_t        fresh [WIN_SIDE];
    bit          border;
    made = 1'b0;
    res = '0;
    w = used_width();
    h = used_height();
    body = w * h;
    lag = 2 * w + 2;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    n = row_cnt * w + c;
    if (n < body) begin
      // drain inside the frame body is dropped without effect
      if (drn) return;
      v = pix;
    end else begin
      v = '0;
    end
    for (int k = 0; k < LINE_COUNT; k++) fresh[LINE_COUNT-1-k] = line_mem[k*MAXW + c];
    fresh[LINE_COUNT] = v;
    for (int k = LINE_COUNT - 1; k > 0; k--) line_mem[k*MAXW + c] = line_mem[(k-1)*MAXW + c];
    line_mem[c] = v;
    for (int i = 0; i < WIN_SIDE; i++) begin
      for (int j = 0; j < WIN_SIDE - 1; j++) win[i][j] = win[i][j+1];
      win[i][WIN_SIDE-1] = fresh[i];
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (n < lag) return;
    p = n - lag;
    rc = p / w;
    cc = p % w;
    border = rc < WIN_REACH || rc + WIN_REACH >= h || cc < WIN_REACH || cc + WIN_REACH >= w;
    if (border || cfg_contrast == 0) res.pix = win[WIN_REACH][WIN_REACH];
    else res.pix = has_dip() ? 8'd0 : WHITE;
    res.last = (p + 1 == body);
    if (res.last) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    made = 1'b1;
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 16);
  endfunction

  function automatic pix_t pick_pixel(input int sty);
    case (sty)
      0: return pix_t'($urandom_range(0, 255));
      // bright field with scattered dark dips
      1: return ($urandom_range(0, 99) < 85) ? pix_t'($urandom_range(160, 255))
                                             : pix_t'($urandom_range(0, 90));
      default: return pix_t'($urandom_range(96, 128));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_contrast();
    logic [DIM_W-1:0] v;
    int unsigned      r;
    r = $urandom_range(0, 9);
    if (r < 2) v[7:0] = 8'd0;
    else if (r < 7) v[7:0] = 8'($urandom_range(1, 30));
    else v[7:0] = 8'($urandom_range(31, 255));
    // bits above the register width are dropped
    v[DIM_W-1:8] = 3'($urandom_range(0, 7));
    return v;
  endfunction

  function automatic plan_row_t plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t plan_beat(input pix_t pix, input logic drn, input logic known,
                                          input pix_t want_pix, input logic want_last);
    plan_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.pix = pix;
    r.drn = drn;
    r.known = known;
    r.want_pix = want_pix;
    r.want_last = want_last;
    return r;
  endfunction

  task automatic push_beat(input pix_t pix, input logic drn, input logic known,
                           input edge_px_t want);
    int unsigned gap;
    bit          made;
    edge_px_t    got;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    drain_in <= drn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edge_map_step(pix, drn, made, got);
    if (known) expected_px.push_back(want);
    else if (made) expected_px.push_back(got);
  endtask

  // registers change only once the pipeline has emptied
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CONTRAST: cfg_contrast = data[7:0];
      CFG_WIDTH: begin
        cfg_w = data;
        col_cnt = 0;
        row_cnt = 0;
      end
      CFG_HEIGHT: begin
        cfg_h = data;
        col_cnt = 0;
        row_cnt = 0;
      end
      default: ;
    endcase
  endtask

  task automatic run_frame(input bit may_abort, input int sty);
    int unsigned w, h, body, cut;
    w = used_width();
    h = used_height();
    body = w * h;
    cut = body;
    in_calm = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    if (may_abort && body > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, body - 1);
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 9) == 0) push_beat(pix_t'($urandom), 1'b1, 1'b0, '0);
      push_beat(pick_pixel(sty), 1'b0, 1'b0, '0);
      beats_done++;
    end
    if (cut < body) begin
      // geometry rewrite mid frame restarts it
      write_reg(CFG_WIDTH, DIM_W'(cfg_w));
      return;
    end
    for (int unsigned i = 0; i < 2 * w + 2; i++) begin
      push_beat(pix_t'($urandom), ($urandom_range(0, 3) != 0), 1'b0, '0);
      beats_done++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin : check_out
    edge_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $display("%0t: result with none expected, pixel_out %0d frame_last %0b",
                 $time, pixel_out, frame_last);
        errors++;
      end else begin
        want = expected_px.pop_front();
        if (pixel_out !== want.pix) begin
          $display("%0t: pixel_out expected %0d got %0d", $time, want.pix, pixel_out);
          errors++;
        end
        if (frame_last !== want.last) begin
          $display("%0t: frame_last expected %0b got %0b", $time, want.last, frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("directional_local_minimum_edge_map_core verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned w, h;
    int          nfr, sty;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;
    cfg_contrast = 0;
    cfg_w = WIDTH_RESET;
    cfg_h = HEIGHT_RESET;

    plan = '{
      // 0 and 0 geometry act as a single pixel frame
      plan_reg(CFG_CONTRAST, 11'd0),
      plan_reg(CFG_WIDTH, 11'd0),
      plan_reg(CFG_HEIGHT, 11'd0),
      plan_beat(8'h5A, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'hA5, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_beat(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b1, 8'hA5, 1'b1),
      // unmapped index must leave the geometry alone
      plan_reg(CFG_UNUSED, 11'h7FF),
      plan_reg(CFG_CONTRAST, 11'h0FF),
      plan_beat(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b1, 8'hFF, 1'b1),
      // restart after one pixel of a two row frame
      plan_reg(CFG_WIDTH, 11'd1),
      plan_reg(CFG_HEIGHT, 11'd2),
      plan_beat(8'h11, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_reg(CFG_WIDTH, 11'd1),
      plan_beat(8'h22, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h33, 1'b0, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b1, 8'h22, 1'b0),
      plan_beat(8'h00, 1'b1, 1'b1, 8'h33, 1'b1)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
      else push_beat(plan[i].pix, plan[i].drn, plan[i].known,
                     {plan[i].want_pix, plan[i].want_last});
    end

    while (beats_done < RANDOM_BEATS) begin
      w = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      h = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      write_reg(CFG_CONTRAST, pick_contrast());
      write_reg(CFG_WIDTH, DIM_W'(w));
      write_reg(CFG_HEIGHT, DIM_W'(h));
      nfr = $urandom_range(1, 2);
      sty = $urandom_range(0, 2);
      repeat (nfr) run_frame(1'b1, sty);
    end

    // contrast at its top with spare bits set
    write_reg(CFG_CONTRAST, 11'h7FF);
    write_reg(CFG_WIDTH, 11'd5);
    write_reg(CFG_HEIGHT, 11'd5);
    run_frame(1'b0, 0);
    // tall single column frame
    write_reg(CFG_CONTRAST, 11'd1);
    write_reg(CFG_WIDTH, 11'd1);
    write_reg(CFG_HEIGHT, 11'd40);
    run_frame(1'b0, 2);

    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (errors == 0) begin
      $display("directional_local_minimum_edge_map_core verification clean");
    end else begin
      $display("directional_local_minimum_edge_map_core verification failed");
    end
    $finish;
  end

endmodule
